FILE: hdl/pbsc_pkg.sv
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared types, sizes and helpers for the priority box span compositor.
// ----------------------------------------------------------------------------
package pbsc_pkg;

    localparam int NUM_SPANS   = 13;
    localparam int INDEX_W     = 4;
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 4;
    localparam int TREE_LEVELS = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1;
    localparam int TREE_WIDTH  = 1 << TREE_LEVELS;

    localparam logic             FUNC_WRITE = 1'b0;
    localparam logic             FUNC_QUERY = 1'b1;
    localparam logic [COLOR_W-1:0] COLOR_MASK = 4'hF;

    // One span candidate as it moves through the priority tree
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] left;
        logic [COLOR_W-1:0] color;
    } cand_t;

    // One accepted request as seen by the span table
    typedef struct packed {
        logic               wr_en;
        logic               qry_en;
        logic [INDEX_W-1:0] index;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } span_req_t;

    // Greatest left edge wins; on a tie the higher-index side wins
    function automatic cand_t pick_cand(cand_t lo, cand_t hi);
        cand_t res;
        if (hi.hit && (!lo.hit || (hi.left >= lo.left))) begin
            res = hi;
        end else begin
            res = lo;
        end
        return res;
    endfunction

endpackage

FILE: hdl/priority_box_span_compositor_unit.sv
// ----------------------------------------------------------------------------
// priority_box_span_compositor_unit
// Span table lookup: color of the covering span with the greatest left edge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one request per s_valid/s_ready handshake. With
//   s_func = write, the request loads span s_entry_index (indexes past the
//   table are dropped) and yields no result. With s_func = query, it asks
//   for the color at (s_pixel_x, s_pixel_y) and yields one result.
//   Result channel (m_*): m_pixel_color, 0 when no span covers the pixel.
//   Throughput: one request per cycle while the result channel is not stalled.
//   Pipeline: a query result passes one compare stage, then one registered
//   pick level per tree level.
//   A write takes effect for every query accepted after it.
//   Reset: aresetn (synchronous, low) clears every span to zero and empties
//   the pipeline.
//   Stall: when m_valid is high and m_ready low the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module priority_box_span_compositor_unit
    import pbsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [INDEX_W-1:0] s_entry_index,
    input  logic [COORD_W-1:0] s_new_left,
    input  logic [COORD_W-1:0] s_new_top,
    input  logic [COORD_W-1:0] s_new_bottom,
    input  logic [COLOR_W-1:0] s_new_color,
    input  logic [COORD_W-1:0] s_pixel_x,
    input  logic [COORD_W-1:0] s_pixel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_pixel_color
);

    logic      advance;
    logic      accept;
    span_req_t req;
    logic      cand_valid;
    cand_t     cands [NUM_SPANS];

    // Advance every stage together unless the result is blocked
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Bundle the accepted request for the table
    always_comb begin
        req.wr_en   = accept && (s_func == FUNC_WRITE);
        req.qry_en  = accept && (s_func == FUNC_QUERY);
        req.index   = s_entry_index;
        req.left    = s_new_left;
        req.top     = s_new_top;
        req.bottom  = s_new_bottom;
        req.color   = s_new_color;
        req.pixel_x = s_pixel_x;
        req.pixel_y = s_pixel_y;
    end

    pbsc_span_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .req        (req),
        .cand_valid (cand_valid),
        .cands      (cands)
    );

    pbsc_max_tree u_tree (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .cand_valid (cand_valid),
        .cands      (cands),
        .out_valid  (m_valid),
        .out_color  (m_pixel_color)
    );

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while result is blocked");

endmodule

FILE: hdl/pbsc_span_table.sv
// ----------------------------------------------------------------------------
// pbsc_span_table
// Span registers and the coverage compare stage, one lane per span.
// ----------------------------------------------------------------------------
module pbsc_span_table
    import pbsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  span_req_t req,
    output logic      cand_valid,
    output cand_t     cands [NUM_SPANS]
);

    logic [COORD_W-1:0] span_left_edge_reg  [NUM_SPANS];
    logic [COORD_W-1:0] span_top_row_reg    [NUM_SPANS];
    logic [COORD_W-1:0] span_bottom_row_reg [NUM_SPANS];
    logic [COLOR_W-1:0] span_palette_reg    [NUM_SPANS];

    logic  valid_reg;
    cand_t cand_reg  [NUM_SPANS];
    cand_t cand_next [NUM_SPANS];

    // Compare against the table as it stands before any later write
    always_comb begin
        for (int k = 0; k < NUM_SPANS; k++) begin
            cand_next[k].hit   = (req.pixel_y >= span_top_row_reg[k]) &&
                                 (req.pixel_y <= span_bottom_row_reg[k]) &&
                                 (req.pixel_x >= span_left_edge_reg[k]);
            cand_next[k].left  = span_left_edge_reg[k];
            cand_next[k].color = span_palette_reg[k];
        end
    end

    // Table: indexes beyond the table match no lane and are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SPANS; k++) begin
                span_left_edge_reg[k]  <= '0;
                span_top_row_reg[k]    <= '0;
                span_bottom_row_reg[k] <= '0;
                span_palette_reg[k]    <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_SPANS; k++) begin
                if (req.wr_en && (32'(req.index) == k)) begin
                    span_left_edge_reg[k]  <= req.left;
                    span_top_row_reg[k]    <= req.top;
                    span_bottom_row_reg[k] <= req.bottom;
                    span_palette_reg[k]    <= req.color & COLOR_MASK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= req.qry_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < NUM_SPANS; k++) begin
                cand_reg[k] <= cand_next[k];
            end
        end
    end

    assign cand_valid = valid_reg;
    assign cands      = cand_reg;

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |=> !valid_reg)
        else $error("write request produced a pipeline result");

    a_query_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        req.qry_en |=> valid_reg)
        else $error("pixel request did not enter the pipeline");

endmodule

FILE: hdl/pbsc_max_tree.sv
// ----------------------------------------------------------------------------
// pbsc_max_tree
// Pipelined priority tree: one registered pick level per stage.
// ----------------------------------------------------------------------------
module pbsc_max_tree
    import pbsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               cand_valid,
    input  cand_t              cands [NUM_SPANS],
    output logic               out_valid,
    output logic [COLOR_W-1:0] out_color
);

    cand_t leaf      [TREE_WIDTH];
    cand_t node_reg  [1:TREE_WIDTH-1];
    cand_t node_next [1:TREE_WIDTH-1];

    logic [TREE_LEVELS-1:0] vld_reg;

    // Pad unused leaves with misses
    for (genvar i = 0; i < TREE_WIDTH; i++) begin : g_leaf
        if (i < NUM_SPANS) begin : g_used
            assign leaf[i] = cands[i];
        end else begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // Heap layout: node i picks between children 2i (lower) and 2i+1
    for (genvar i = 1; i < TREE_WIDTH; i++) begin : g_node
        if (2 * i >= TREE_WIDTH) begin : g_bottom
            assign node_next[i] = pick_cand(leaf[2*i-TREE_WIDTH], leaf[2*i+1-TREE_WIDTH]);
        end else begin : g_inner
            assign node_next[i] = pick_cand(node_reg[2*i], node_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 1; i < TREE_WIDTH; i++) begin
                node_reg[i] <= node_next[i];
            end
        end
    end

    // vld_reg[d] tags the nodes at depth d; new valid enters at the deepest level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= TREE_LEVELS'({cand_valid, vld_reg} >> 1);
        end
    end

    assign out_valid = vld_reg[0];
    assign out_color = node_reg[1].hit ? node_reg[1].color : '0;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(vld_reg) && $stable(out_color))
        else $error("tree moved while stalled");

endmodule

FILE: tb/tb_priority_box_span_compositor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_box_span_compositor_unit
// Self-checking testbench for the priority box span compositor.
// Drives span writes and pixel queries over the request channel. It tracks
// its own copy of the span table and predicts each pixel color. Every result
// is checked in order against the oldest prediction. Directed tests cover
// reset, priority, ties and corner cases. Random traffic then runs under
// several source and sink idling mixes.
// ----------------------------------------------------------------------------
module tb_priority_box_span_compositor_unit;
    import pbsc_pkg::*;

    // Cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT     = 3000;
    // Pipeline depth of a query, plus margin, for the final settle
    localparam int SETTLE_CYCLES  = 1 + TREE_LEVELS + 4;
    localparam int PHASE_REQUESTS = 220;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [INDEX_W-1:0] s_entry_index;
    logic [COORD_W-1:0] s_new_left;
    logic [COORD_W-1:0] s_new_top;
    logic [COORD_W-1:0] s_new_bottom;
    logic [COLOR_W-1:0] s_new_color;
    logic [COORD_W-1:0] s_pixel_x;
    logic [COORD_W-1:0] s_pixel_y;
    logic               m_valid;
    logic               m_ready;
    logic [COLOR_W-1:0] m_pixel_color;

    // Shadow span table, updated in request order
    logic [COORD_W-1:0] shadow_left   [NUM_SPANS];
    logic [COORD_W-1:0] shadow_top    [NUM_SPANS];
    logic [COORD_W-1:0] shadow_bottom [NUM_SPANS];
    logic [COLOR_W-1:0] shadow_color  [NUM_SPANS];

    // Predicted colors of queries still in flight, oldest first
    logic [COLOR_W-1:0] pending_colors[$];

    int mismatch_count;
    int quiet_cycles;
    int src_idle_pct;
    int sink_stall_pct;

    priority_box_span_compositor_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_new_left    (s_new_left),
        .s_new_top     (s_new_top),
        .s_new_bottom  (s_new_bottom),
        .s_new_color   (s_new_color),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Winning color at (px, py): greatest covering left edge, later index on a tie
    function automatic logic [COLOR_W-1:0] winning_color(logic [COORD_W-1:0] px,
                                                         logic [COORD_W-1:0] py);
        logic [COLOR_W-1:0] best_color;
        logic [COORD_W-1:0] best_left;
        best_color = '0;
        best_left  = '0;
        for (int k = 0; k < NUM_SPANS; k++) begin
            if (py >= shadow_top[k] && py <= shadow_bottom[k] && px >= shadow_left[k] &&
                shadow_left[k] >= best_left) begin
                best_color = shadow_color[k] & COLOR_MASK;
                best_left  = shadow_left[k];
            end
        end
        return best_color;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Send one request, idling first per the source mix, then wait for acceptance
    task automatic send_request(input logic               func,
                                input logic [INDEX_W-1:0] idx,
                                input logic [COORD_W-1:0] left,
                                input logic [COORD_W-1:0] top,
                                input logic [COORD_W-1:0] bottom,
                                input logic [COLOR_W-1:0] color,
                                input logic [COORD_W-1:0] px,
                                input logic [COORD_W-1:0] py);
        // Drop valid for as many idle cycles as the source mix draws
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_entry_index <= idx;
        s_new_left    <= left;
        s_new_top     <= top;
        s_new_bottom  <= bottom;
        s_new_color   <= color;
        s_pixel_x     <= px;
        s_pixel_y     <= py;
        // Hold the request until the block takes it
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (func == FUNC_WRITE) begin
            if (idx < NUM_SPANS) begin
                shadow_left[idx]   = left;
                shadow_top[idx]    = top;
                shadow_bottom[idx] = bottom;
                shadow_color[idx]  = color;
            end
        end else begin
            pending_colors.push_back(winning_color(px, py));
        end
    endtask

    // Span write; the query fields carry random noise
    task automatic write_span(input logic [INDEX_W-1:0] idx,
                              input logic [COORD_W-1:0] left,
                              input logic [COORD_W-1:0] top,
                              input logic [COORD_W-1:0] bottom,
                              input logic [COLOR_W-1:0] color);
        send_request(FUNC_WRITE, idx, left, top, bottom, color,
                     COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Pixel query; the write fields carry random noise
    task automatic query_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        send_request(FUNC_QUERY, INDEX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COLOR_W'($urandom), px, py);
    endtask

    // Drop valid and hold off until every predicted color has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_colors.size() != 0);
    endtask

    // Random traffic: mostly sane spans and queries aimed at them, plus noise
    task automatic run_random_traffic(input int count);
        int                 k;
        int                 lo;
        int                 hi;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 30) begin
                top  = COORD_W'($urandom);
                left = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 15) * 16)
                                                   : COORD_W'($urandom);
                if ($urandom_range(0, 9) == 0) begin
                    bottom = COORD_W'($urandom);
                end else begin
                    bottom = COORD_W'($urandom_range(top, 255));
                end
                write_span(INDEX_W'($urandom), left, top, bottom, COLOR_W'($urandom));
            end else if ($urandom_range(0, 99) < 30) begin
                query_pixel(COORD_W'($urandom), COORD_W'($urandom));
            end else begin
                // Aim inside one span so overlaps and ties get exercised
                k  = $urandom_range(0, NUM_SPANS - 1);
                lo = shadow_top[k];
                hi = shadow_bottom[k];
                py = (lo <= hi) ? COORD_W'($urandom_range(lo, hi)) : COORD_W'($urandom);
                lo = shadow_left[k];
                hi = (lo + 8 > 255) ? 255 : lo + 8;
                px = COORD_W'($urandom_range(lo, hi));
                query_pixel(px, py);
            end
        end
        drain_results();
    endtask

    // After reset every span sits at row 0, left 0, color 0
    task automatic test_reset_state();
        query_pixel(8'd0, 8'd0);
        query_pixel(8'd255, 8'd255);
        query_pixel(8'd255, 8'd0);
        drain_results();
    endtask

    // Greatest left edge wins; on equal left the higher index wins
    task automatic test_priority_tie();
        write_span(4'd0, 8'd10, 8'd0, 8'd255, 4'd3);
        write_span(4'd5, 8'd10, 8'd0, 8'd255, 4'd7);
        write_span(4'd12, 8'd255, 8'd255, 8'd255, 4'd15);
        query_pixel(8'd10, 8'd5);
        query_pixel(8'd9, 8'd5);
        query_pixel(8'd255, 8'd255);
        query_pixel(8'd254, 8'd255);
        drain_results();
    endtask

    // Writes past the last span must leave the table untouched
    task automatic test_bad_index();
        write_span(4'd13, 8'd200, 8'd0, 8'd255, 4'd9);
        write_span(4'd15, 8'd200, 8'd0, 8'd255, 4'd9);
        query_pixel(8'd255, 8'd100);
        drain_results();
    endtask

    // A span with top below bottom covers nothing
    task automatic test_empty_span();
        write_span(4'd3, 8'd100, 8'd100, 8'd50, 4'd2);
        query_pixel(8'd150, 8'd75);
        query_pixel(8'd150, 8'd100);
        drain_results();
    endtask

    // A covering span of color zero still wins over a lower left edge
    task automatic test_zero_color();
        write_span(4'd7, 8'd50, 8'd0, 8'd255, 4'd0);
        query_pixel(8'd60, 8'd20);
        query_pixel(8'd49, 8'd20);
        drain_results();
    endtask

    task automatic test_random_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_traffic(PHASE_REQUESTS);
    endtask

    task automatic test_random_slow_source();
        src_idle_pct   = 88;
        sink_stall_pct = 0;
        run_random_traffic(PHASE_REQUESTS);
    endtask

    task automatic test_random_slow_sink();
        src_idle_pct   = 0;
        sink_stall_pct = 88;
        run_random_traffic(PHASE_REQUESTS);
    endtask

    task automatic test_random_both_idle();
        src_idle_pct   = 21;
        sink_stall_pct = 21;
        run_random_traffic(PHASE_REQUESTS);
    endtask

    // Sink side: toggle ready per the stall mix
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Check each accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected result color %0h", m_pixel_color));
            end else if (m_pixel_color !== pending_colors[0]) begin
                report_mismatch($sformatf("pixel_color got %0h want %0h",
                                          m_pixel_color, pending_colors[0]));
                void'(pending_colors.pop_front());
            end else begin
                void'(pending_colors.pop_front());
            end
        end
    end

    // Hang detection: count cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        // Drive every input to a known value before the first edge
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_func         = FUNC_WRITE;
        s_entry_index  = '0;
        s_new_left     = '0;
        s_new_top      = '0;
        s_new_bottom   = '0;
        s_new_color    = '0;
        s_pixel_x      = '0;
        s_pixel_y      = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int k = 0; k < NUM_SPANS; k++) begin
            shadow_left[k]   = '0;
            shadow_top[k]    = '0;
            shadow_bottom[k] = '0;
            shadow_color[k]  = '0;
        end

        // Hold reset low for a while, then release it once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_priority_tie();
        test_bad_index();
        test_empty_span();
        test_zero_color();
        test_random_no_idle();
        test_random_slow_source();
        test_random_slow_sink();
        test_random_both_idle();
        test_random_no_idle();

        // Let the pipeline settle, then make sure nothing else comes out
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
